// ----- rtl/secded_24_18_checker_macros.svh -----
// assertion macros for the secded checker
`ifndef SECDED_24_18_CHECKER_MACROS_SVH
`define SECDED_24_18_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// check that holds only while out of reset
`define SDC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("secded checker assertion failed");

// check that also covers the reset cycles
`define SDC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("secded checker reset assertion failed");

`else

`define SDC_ASSERT(label, prop)
`define SDC_ASSERT_RST(label, prop)

`endif

`endif

// ----- rtl/secded_pkg.sv -----
package secded_pkg;

  localparam int unsigned WORD_W   = 24;
  localparam int unsigned SYN_W    = 5;
  localparam int unsigned LAST_POS = 23;

  // decode outcome codes
  typedef enum logic [2:0] {
    ST_CLEAN         = 3'd0,
    ST_OVERALL       = 3'd1,
    ST_SINGLE        = 3'd2,
    ST_DOUBLE        = 3'd3,
    ST_UNCORRECTABLE = 3'd4
  } status_t;

  // one decoded result
  typedef struct packed {
    logic [WORD_W-1:0] corrected_word;
    status_t           status;
    logic [SYN_W-1:0]  error_position;
  } dec_res_t;

  // word bits covered by syndrome check k: positions 1..23 with bit k set
  function automatic logic [WORD_W-1:0] check_mask(input int unsigned k);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int unsigned pos = 1; pos <= LAST_POS; pos++) begin
      if (((pos >> k) & 1) != 0) begin
        m[pos-1] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/secded_ifs.sv -----
// input channel: one received codeword per transaction
interface secded_in_if;
  logic                             valid;
  logic                             ready;
  logic [secded_pkg::WORD_W-1:0]    codeword;

  modport source (output valid, output codeword, input ready);
  modport sink   (input valid, input codeword, output ready);
endinterface

// result channel: corrected word, status and error position per transaction
interface secded_out_if;
  logic                             valid;
  logic                             ready;
  logic [secded_pkg::WORD_W-1:0]    corrected_word;
  logic [2:0]                       status;
  logic [secded_pkg::SYN_W-1:0]     error_position;

  modport source (output valid, output corrected_word, output status,
                  output error_position, input ready);
  modport sink   (input valid, input corrected_word, input status,
                  input error_position, output ready);
endinterface

// ----- rtl/secded_decode.sv -----
module secded_decode (
  input  logic [secded_pkg::WORD_W-1:0] codeword,
  output secded_pkg::dec_res_t          res
);
  import secded_pkg::*;

  logic [SYN_W-1:0] syndrome;
  logic             overall;

  // odd parity checks, syndrome bit is the inverted check
  for (genvar k = 0; k < SYN_W; k++) begin : g_syn
    localparam logic [WORD_W-1:0] MASK = check_mask(k);
    assign syndrome[k] = ~(^(codeword & MASK));
  end

  assign overall = ^codeword;

  // classify and correct
  always_comb begin
    res.corrected_word = codeword;
    res.status         = ST_CLEAN;
    res.error_position = '0;
    priority if (syndrome == '0) begin
      res.status = overall ? ST_CLEAN : ST_OVERALL;
    end else if (overall) begin
      res.status = ST_DOUBLE;
    end else if (syndrome <= SYN_W'(LAST_POS)) begin
      res.status         = ST_SINGLE;
      res.corrected_word = codeword ^ (WORD_W'(1) << (syndrome - SYN_W'(1)));
      res.error_position = syndrome;
    end else begin
      res.status = ST_UNCORRECTABLE;
    end
  end

endmodule

// ----- rtl/secded_24_18_checker.sv -----
// channel  dir  payload                                  handshake
// in_ch    in   codeword[23:0]                           valid/ready
// out_ch   out  corrected_word[23:0] status[2:0]         valid/ready
//               error_position[4:0]
//
// from input transaction to result transaction a word passes the input register,
// then decode logic into the result register
// throughput is one word per clock while the result side takes every cycle
// reset (rst_n, synchronous, active low) empties both stages
// a stalled result holds in the result register; one more word still waits
// in the input register, after which in_ch.ready drops

`include "secded_24_18_checker_macros.svh"

module secded_24_18_checker (
  input  logic         clk,
  input  logic         rst_n,
  secded_in_if.sink    in_ch,
  secded_out_if.source out_ch
);
  import secded_pkg::*;

  logic              in_valid_r;
  logic [WORD_W-1:0] in_word_r;
  logic              out_valid_r;
  dec_res_t          out_res_r;
  dec_res_t          dec_res;
  logic              out_load;
  logic              in_take;

  // stage movement
  assign out_load    = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || out_load;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_ch.codeword;
    end
  end

  // syndrome decode and correction
  secded_decode u_decode (
    .codeword (in_word_r),
    .res      (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= dec_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.corrected_word = out_res_r.corrected_word;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.error_position = out_res_r.error_position;

  // a position is reported only for a corrected single error
  `SDC_ASSERT(a_pos_only_single, out_valid_r && out_res_r.status != ST_SINGLE
              |-> out_res_r.error_position == '0)
  // a corrected position lies inside the word
  `SDC_ASSERT(a_pos_in_range, out_valid_r && out_res_r.status == ST_SINGLE
              |-> out_res_r.error_position != '0
                  && out_res_r.error_position <= SYN_W'(LAST_POS))
  // a loaded word appears on the result side next cycle
  `SDC_ASSERT(a_load_shows, out_load |=> out_valid_r)
  // reset leaves both stages empty
  `SDC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !in_valid_r)

endmodule

// ----- sim/secded_24_18_checker_test.sv -----
module secded_24_18_checker_test;
  import secded_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned PRINT_CAP   = 40;

  logic clk;
  logic rst_n;

  secded_in_if  in_ch();
  secded_out_if out_ch();

  secded_24_18_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dec_res_t    pending_decodes[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_trig;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted decode of one received word
  function automatic dec_res_t decode_word(input logic [WORD_W-1:0] w);
    logic [SYN_W-1:0] pos_sum;
    logic [SYN_W-1:0] syn;
    logic             odd;
    dec_res_t         r;
    pos_sum = '0;
    for (int p = 1; p <= LAST_POS; p++) begin
      if (w[p-1]) begin
        pos_sum ^= SYN_W'(p);
      end
    end
    // odd parity: a clean check gives 1, syndrome bit is its inverse
    syn = ~pos_sum;
    odd = ^w;
    r.corrected_word = w;
    r.status         = ST_CLEAN;
    r.error_position = '0;
    if (syn == '0) begin
      r.status = odd ? ST_CLEAN : ST_OVERALL;
    end else if (odd) begin
      r.status = ST_DOUBLE;
    end else if (syn <= LAST_POS) begin
      r.status         = ST_SINGLE;
      r.corrected_word = w ^ (WORD_W'(1) << (syn - 1));
      r.error_position = syn;
    end else begin
      r.status = ST_UNCORRECTABLE;
    end
    return r;
  endfunction

  // build a clean codeword from 18 data bits
  function automatic logic [WORD_W-1:0] make_codeword(input logic [17:0] data);
    logic [WORD_W-1:0] w;
    logic [SYN_W-1:0]  pos_sum;
    logic [SYN_W-1:0]  need;
    int                i;
    w       = '0;
    pos_sum = '0;
    i       = 0;
    // data fills the positions that are not powers of two
    for (int p = 1; p <= LAST_POS; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = data[i];
        if (data[i]) begin
          pos_sum ^= SYN_W'(p);
        end
        i++;
      end
    end
    // check bits make every check come out 1
    need = pos_sum ^ {SYN_W{1'b1}};
    for (int k = 0; k < SYN_W; k++) begin
      w[(1 << k) - 1] = need[k];
    end
    w[WORD_W-1] = ~^w[WORD_W-2:0];
    return w;
  endfunction

  // flip n distinct random bits of a word
  function automatic logic [WORD_W-1:0] flip_bits(input logic [WORD_W-1:0] w,
                                                  input int unsigned n);
    logic [WORD_W-1:0] hit;
    int unsigned       b;
    hit = '0;
    while ($countones(hit) < n) begin
      b = $urandom_range(WORD_W - 1);
      hit[b] = 1'b1;
    end
    return w ^ hit;
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t decode mismatch on %s: got %h want %h", $realtime, field, got, want);
    end
    mismatch_count++;
  endtask

  // offer one word, leave valid high for a back-to-back follower
  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.codeword <= w;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // result side ready, with random stalls and a long hold on request
  initial begin
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // predict on each input transaction, compare on each result transaction
  always @(posedge clk) begin
    dec_res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_decodes.push_back(decode_word(in_ch.codeword));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("unexpected result", out_ch.corrected_word, '0);
        end else begin
          want = pending_decodes.pop_front();
          if (out_ch.corrected_word !== want.corrected_word) begin
            report_mismatch("corrected_word", out_ch.corrected_word, want.corrected_word);
          end
          if (out_ch.status !== want.status) begin
            report_mismatch("status", WORD_W'(out_ch.status), WORD_W'(want.status));
          end
          if (out_ch.error_position !== want.error_position) begin
            report_mismatch("error_position", WORD_W'(out_ch.error_position),
                            WORD_W'(want.error_position));
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // extremes and every decode outcome
  task automatic test_directed();
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] f;
    z = make_codeword(18'h00000);
    f = make_codeword(18'h3ffff);
    send_word(z);
    send_word(f);
    send_word(24'h000000);
    send_word(24'hffffff);
    // overall parity bit wrong
    send_word(z ^ 24'h800000);
    send_word(f ^ 24'h800000);
    // single errors at check bits, the top covered bit and a data bit
    send_word(z ^ 24'h000001);
    send_word(f ^ 24'h000002);
    send_word(z ^ 24'h008000);
    send_word(f ^ 24'h400000);
    send_word(z ^ 24'h000020);
    // double errors
    send_word(z ^ 24'h000003);
    send_word(f ^ 24'h810000);
    // syndrome past the word: positions 16, 12, 4 and 16, 8, 7
    send_word(z ^ 24'h008808);
    send_word(f ^ 24'h0080c0);
    send_word(z ^ 24'h0080c0);
  endtask

  // mostly coded words with injected errors, some raw noise
  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count);
    logic [WORD_W-1:0] w;
    int unsigned       kind;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      w    = make_codeword(18'($urandom));
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_word(w);
      end else if (kind < 60) begin
        send_word(flip_bits(w, 1));
      end else if (kind < 75) begin
        send_word(flip_bits(w, 2));
      end else if (kind < 88) begin
        send_word(flip_bits(w, 3));
      end else begin
        send_word(WORD_W'($urandom));
      end
    end
  endtask

  // long result hold while words keep coming, so the input side stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trig      = ~hold_trig;
    repeat (40) begin
      send_word(flip_bits(make_codeword(18'($urandom)), $urandom_range(2)));
    end
  endtask

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trig      = 1'b0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.codeword <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 180);
    test_random(83, 0, 180);
    test_random(0, 83, 180);
    test_random(34, 34, 180);
    test_backpressure();

    // drain
    in_ch.valid <= 1'b0;
    recv_stall_pct = 34;
    while (pending_decodes.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/secded_pkg.sv
rtl/secded_ifs.sv
rtl/secded_decode.sv
rtl/secded_24_18_checker.sv
sim/secded_24_18_checker_test.sv
